/* hdl/mcl_pkg.sv */
// Shared constants, codes and types for the multiband clamped lookup block.
`timescale 1ns / 1ps
package mcl_pkg;

   // Default configuration of the table store.
   localparam int BANDS_DEF       = 3;
   localparam int TABLE_DEPTH_DEF = 1024;

   // Fixed field widths.
   localparam int SAMPLE_W = 16;
   localparam int ENTRY_W  = 16;
   localparam int INDEX_W  = 10;
   localparam int BAND_W   = 2;
   localparam int COUNT_W  = 11;
   localparam int MODE_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Stream widths.
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   // Depth of the result queue that decouples the pipeline from the receiver.
   localparam int RSP_FIFO_DEPTH = 4;

   // Width used for the signed clamp arithmetic.
   localparam int CLAMP_W = 18;

   // Command codes carried in req_tuser.
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_WRITE  = 1'b1;

   // Output format codes.
   typedef enum logic [MODE_W-1:0] {
      MODE_VALUE = 2'd0,
      MODE_BYTE  = 2'd1,
      MODE_BIT   = 2'd2
   } out_mode_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CFG_OUT_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_OFFSET_BASE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_COUNT_BASE  = 3'd4;

   // Access strobes toward the table memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } tbl_ctl_type;

   // One formatted result word.
   typedef struct packed {
      logic [BAND_W-1:0]  band;
      logic [ENTRY_W-1:0] value;
   } rsp_word_type;

endpackage

/* hdl/mcl_addr.sv */
// Band selection, count saturation and sample clamp into a table address.
`timescale 1ns / 1ps
module mcl_addr #(
   parameter int BANDS       = mcl_pkg::BANDS_DEF,
   parameter int TABLE_DEPTH = mcl_pkg::TABLE_DEPTH_DEF,
   parameter int ADDR_W      = (BANDS * TABLE_DEPTH > 1) ? $clog2(BANDS * TABLE_DEPTH) : 1
) (
   input  logic                                valid,
   input  logic                                cmd,
   input  logic [mcl_pkg::BAND_W-1:0]          band,
   input  logic signed [mcl_pkg::SAMPLE_W-1:0] sample,
   input  logic [mcl_pkg::INDEX_W-1:0]         entry_index,
   input  logic signed [mcl_pkg::SAMPLE_W-1:0] offsets [BANDS],
   input  logic [mcl_pkg::COUNT_W-1:0]         counts [BANDS],
   output mcl_pkg::tbl_ctl_type                ctl,
   output logic [ADDR_W-1:0]                   addr
);
   import mcl_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic signed [SAMPLE_W-1:0] off_sel;
   logic [COUNT_W-1:0]         cnt_raw;
   logic signed [CLAMP_W-1:0]  cnt;
   logic signed [CLAMP_W-1:0]  diff;
   logic signed [CLAMP_W-1:0]  ent_wide;
   logic [IDX_W-1:0]           ent;

   // Band values beyond the table set never reach this stage.
   always_comb begin
      off_sel = offsets[0];
      cnt_raw = counts[0];
      for (int b = 1; b < BANDS; b++) begin
         if (band == BAND_W'(b)) begin
            off_sel = offsets[b];
            cnt_raw = counts[b];
         end
      end
   end

   // Count is saturated into one..TABLE_DEPTH.
   always_comb begin
      priority if (cnt_raw == '0) begin
         cnt = CLAMP_W'(1);
      end else if ({{(CLAMP_W-COUNT_W){1'b0}}, cnt_raw} > CLAMP_W'(TABLE_DEPTH)) begin
         cnt = CLAMP_W'(TABLE_DEPTH);
      end else begin
         cnt = {{(CLAMP_W-COUNT_W){1'b0}}, cnt_raw};
      end
   end

   assign diff = CLAMP_W'(sample) - CLAMP_W'(off_sel);

   always_comb begin
      priority if (diff < 0) begin
         ent_wide = '0;
      end else if (diff >= cnt) begin
         ent_wide = cnt - CLAMP_W'(1);
      end else begin
         ent_wide = diff;
      end
   end

   always_comb begin
      if (cmd == CMD_WRITE) begin
         ent = IDX_W'(entry_index);
      end else begin
         ent = ent_wide[IDX_W-1:0];
      end
   end

   assign addr = ADDR_W'(band) * ADDR_W'(TABLE_DEPTH) + ADDR_W'(ent);

   assign ctl.wr_en = valid && (cmd == CMD_WRITE);
   assign ctl.rd_en = valid && (cmd == CMD_LOOKUP);

endmodule

/* hdl/mcl_table.sv */
// Single-port table memory holding the entries of all bands.
`timescale 1ns / 1ps
module mcl_table #(
   parameter int BANDS       = mcl_pkg::BANDS_DEF,
   parameter int TABLE_DEPTH = mcl_pkg::TABLE_DEPTH_DEF,
   parameter int ADDR_W      = (BANDS * TABLE_DEPTH > 1) ? $clog2(BANDS * TABLE_DEPTH) : 1
) (
   input  logic                              clock,
   input  mcl_pkg::tbl_ctl_type              ctl,
   input  logic [ADDR_W-1:0]                 addr,
   input  logic [mcl_pkg::ENTRY_W-1:0]       wdata,
   output logic [mcl_pkg::ENTRY_W-1:0]       rdata
);
   import mcl_pkg::*;

   localparam int WORDS = BANDS * TABLE_DEPTH;

   logic [ENTRY_W-1:0] mem [WORDS];
   logic [ENTRY_W-1:0] rdata_ff;

   // Contents are undefined until written, so the array has no reset.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/mcl_rsp_fifo.sv */
// Small result queue between the lookup pipeline and the output channel.
`timescale 1ns / 1ps
module mcl_rsp_fifo #(
   parameter int DEPTH = mcl_pkg::RSP_FIFO_DEPTH,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mcl_pkg::rsp_word_type push_word,
   input  logic                  pop,
   output logic                  not_empty,
   output mcl_pkg::rsp_word_type head_word,
   output logic [CNT_W-1:0]      fill
);
   import mcl_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rsp_word_type     store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] fill_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_word;
      end
   end

   assign not_empty = (fill_ff != '0);
   assign head_word = store[rd_ptr_ff];
   assign fill      = fill_ff;

endmodule

/* hdl/multiband_clamped_lookup.sv */
// Top level of the multiband clamped lookup: configuration, pipeline and channels.
`timescale 1ns / 1ps
// Maps signed samples through one lookup table per band. A request word either
// writes a table entry (tuser cmd set) or looks up a sample of a band (cmd clear).
// A lookup clamps the sample against the band's offset and entry count: samples
// below the offset read the first entry, samples at or past offset+count read the
// last one. The entry is returned formatted by out_mode as the full value, its low
// byte or its low bit. Write words and words naming a missing band return nothing.
// Throughput is one request word per cycle while req_tready is high. A lookup word is
// registered in stage one, reads the single-port table memory into its read register,
// and its result word then enters the response queue, visible on rsp_tvalid.
// Table writes go through the same memory port, so a lookup right after a write sees it.
// A four-word response queue absorbs receiver stalls: req_tready drops only when
// the queue plus words still in the pipeline would fill it, so nothing is lost.
// Reset clears the pipeline and queue, sets out_mode and offsets to 0 and counts to 1;
// table contents stay undefined until written. The user must write the configuration
// registers (csr_we/csr_index/csr_wdata) only while idle; the block does not enforce it.
module multiband_clamped_lookup #(
   parameter int BANDS       = mcl_pkg::BANDS_DEF,
   parameter int TABLE_DEPTH = mcl_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata: sample [15:0], entry_index [25:16], entry_value [41:26], zero pad.
   input  logic [mcl_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: cmd [0], band [2:1].
   input  logic [mcl_pkg::REQ_USER_W-1:0]      req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata: out_value [15:0].
   output logic [mcl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: out_band [1:0].
   output logic [mcl_pkg::RSP_USER_W-1:0]      rsp_tuser,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [mcl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mcl_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mcl_pkg::*;

   localparam int ADDR_W = (BANDS * TABLE_DEPTH > 1) ? $clog2(BANDS * TABLE_DEPTH) : 1;
   localparam int FCNT_W = $clog2(RSP_FIFO_DEPTH + 1);
   localparam int OCC_W  = FCNT_W + 1;

   // Configuration registers.
   logic [MODE_W-1:0]          out_mode_ff;
   logic signed [SAMPLE_W-1:0] offset_ff [BANDS];
   logic [COUNT_W-1:0]         count_ff [BANDS];

   // Unpacked request fields.
   logic                       req_cmd;
   logic [BAND_W-1:0]          req_band;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic [INDEX_W-1:0]         req_index;
   logic [ENTRY_W-1:0]         req_value;
   logic                       req_accept;
   logic                       req_keep;

   // Stage one: registered request.
   logic                       s1_valid_ff;
   logic                       s1_cmd_ff;
   logic [BAND_W-1:0]          s1_band_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic [INDEX_W-1:0]         s1_index_ff;
   logic [ENTRY_W-1:0]         s1_value_ff;

   // Stage two: table read in flight.
   logic                       s2_valid_ff;
   logic [BAND_W-1:0]          s2_band_ff;

   tbl_ctl_type                tbl_ctl;
   logic [ADDR_W-1:0]          tbl_addr;
   logic [ENTRY_W-1:0]         tbl_rdata;
   rsp_word_type               fmt_word;
   rsp_word_type               head_word;
   logic                       fifo_not_empty;
   logic [FCNT_W-1:0]          fifo_fill;
   logic [OCC_W-1:0]           occupancy;
   logic                       rsp_pop;

   assign req_sample = req_tdata[15:0];
   assign req_index  = req_tdata[25:16];
   assign req_value  = req_tdata[41:26];
   assign req_cmd    = req_tuser[0];
   assign req_band   = req_tuser[2:1];

   assign req_accept = req_tvalid && req_tready;

   // Words for a missing band, and writes past the table end, are dropped here.
   assign req_keep = (32'(req_band) < BANDS) &&
                     ((req_cmd == CMD_LOOKUP) || (32'(req_index) < TABLE_DEPTH));

   // Every lookup in the pipeline has a reserved queue slot.
   assign occupancy = OCC_W'(fifo_fill)
                    + OCC_W'(s1_valid_ff && (s1_cmd_ff == CMD_LOOKUP))
                    + OCC_W'(s2_valid_ff);
   assign req_tready = (occupancy < OCC_W'(RSP_FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_mode_ff <= MODE_VALUE;
         for (int b = 0; b < BANDS; b++) begin
            offset_ff[b] <= '0;
            count_ff[b]  <= COUNT_W'(1);
         end
      end else if (csr_we) begin
         if (csr_index == CFG_OUT_MODE) begin
            out_mode_ff <= csr_wdata[MODE_W-1:0];
         end
         for (int b = 0; b < BANDS; b++) begin
            if (csr_index == CFG_OFFSET_BASE + CSR_IDX_W'(b)) begin
               offset_ff[b] <= csr_wdata;
            end
            if (csr_index == CFG_COUNT_BASE + CSR_IDX_W'(b)) begin
               count_ff[b] <= csr_wdata[COUNT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept && req_keep;
         s2_valid_ff <= tbl_ctl.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff    <= req_cmd;
         s1_band_ff   <= req_band;
         s1_sample_ff <= req_sample;
         s1_index_ff  <= req_index;
         s1_value_ff  <= req_value;
      end
      s2_band_ff <= s1_band_ff;
   end

   mcl_addr #(
      .BANDS       (BANDS),
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_addr (
      .valid       (s1_valid_ff),
      .cmd         (s1_cmd_ff),
      .band        (s1_band_ff),
      .sample      (s1_sample_ff),
      .entry_index (s1_index_ff),
      .offsets     (offset_ff),
      .counts      (count_ff),
      .ctl         (tbl_ctl),
      .addr        (tbl_addr)
   );

   mcl_table #(
      .BANDS       (BANDS),
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_table (
      .clock (clock),
      .ctl   (tbl_ctl),
      .addr  (tbl_addr),
      .wdata (s1_value_ff),
      .rdata (tbl_rdata)
   );

   // Output formatting; the unused mode code behaves as the full value.
   always_comb begin
      fmt_word.band = s2_band_ff;
      unique case (out_mode_ff)
         MODE_BYTE: fmt_word.value = {8'd0, tbl_rdata[7:0]};
         MODE_BIT:  fmt_word.value = {15'd0, tbl_rdata[0]};
         default:   fmt_word.value = tbl_rdata;
      endcase
   end

   assign rsp_pop = rsp_tvalid && rsp_tready;

   mcl_rsp_fifo #(
      .DEPTH (RSP_FIFO_DEPTH),
      .CNT_W (FCNT_W)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_word (fmt_word),
      .pop       (rsp_pop),
      .not_empty (fifo_not_empty),
      .head_word (head_word),
      .fill      (fifo_fill)
   );

   assign rsp_tvalid = fifo_not_empty;
   assign rsp_tdata  = head_word.value;
   assign rsp_tuser  = head_word.band;

endmodule
